// File: src/pnm_header_parser_macros.svh
// assertion macros shared by the pnm header parser modules
`ifndef PNM_HEADER_PARSER_MACROS_SVH
`define PNM_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define PNM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PNM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PNM_ASSERT_IMPL(lbl, ante, cons, msg)

`define PNM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/pnm_hp_pkg.sv
// types and constants of the pnm header parser
`default_nettype none

package pnm_hp_pkg;

   typedef enum logic [3:0] {
      PH_SEEK_MAGIC = 4'd0,
      PH_MAGIC2     = 4'd1,
      PH_SEEK_W     = 4'd2,
      PH_NUM_W      = 4'd3,
      PH_SEEK_H     = 4'd4,
      PH_NUM_H      = 4'd5,
      PH_SEEK_MAX   = 4'd6,
      PH_NUM_MAX    = 4'd7,
      PH_DATA       = 4'd8,
      PH_HALT       = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   localparam logic [2:0] IK_UNKNOWN = 3'd0;
   localparam logic [2:0] IK_GRAY8   = 3'd1;
   localparam logic [2:0] IK_GRAY16  = 3'd2;
   localparam logic [2:0] IK_RGB24   = 3'd3;
   localparam logic [2:0] IK_RGB48   = 3'd4;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_VT    = 8'h0b;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_SIX   = 8'h36;

   localparam int unsigned DEC_RADIX    = 10;
   localparam int unsigned MAXVAL_WIDE  = 256;
   localparam int unsigned MAXVAL_LIMIT = 65536;

   localparam logic [15:0] SAMPLE_MAX = 16'hffff;

   typedef struct packed {
      logic        emit;
      kind_type    kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] max_sample;
      logic [2:0]  image_kind;
      logic [7:0]  pixel_byte;
   } result_type;

endpackage

`default_nettype wire

// File: src/pnm_hp_parse.sv
// parse state registers and the per-byte step logic
`default_nettype none

`include "pnm_header_parser_macros.svh"

module pnm_hp_parse #(
   parameter int DIM_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire logic [7:0]             stream_byte,
   input  wire logic                   file_start,
   output pnm_hp_pkg::result_type      result
);

   localparam int ACC_BITS = (DIM_BITS > 16) ? DIM_BITS : 17;
   localparam int PROD_W = ACC_BITS + 4;
   localparam logic [63:0] DIM_MAX = (64'd1 << DIM_BITS) - 64'd1;
   localparam logic [63:0] ACC_CAP = (DIM_MAX > 64'd65536) ? DIM_MAX : 64'd65536;

   pnm_hp_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic                  comment_ff, comment_in, eff_comment;
   logic [ACC_BITS-1:0]   acc_ff, acc_in, eff_acc;
   logic [7:0]            magic_ff, magic_in, eff_magic;
   logic [DIM_BITS-1:0]   width_ff, width_in, eff_width;
   logic [DIM_BITS-1:0]   height_ff, height_in, eff_height;

   logic                  is_space, is_digit;
   logic                  seek_any, num_any;
   logic                  tok_end;
   logic                  field_w, field_h, field_max;
   logic [ACC_BITS-1:0]   tok_val;
   logic [DIM_BITS-1:0]   tok_dim;
   logic [ACC_BITS-1:0]   acc_base;
   logic [3:0]            digit_val;
   logic [PROD_W-1:0]     acc_prod;
   logic [ACC_BITS-1:0]   acc_next;
   logic                  magic_known;
   logic                  too_large;
   logic [31:0]           width_ext, height_ext;

   // a start beat parses against the reset state
   assign eff_phase   = file_start ? pnm_hp_pkg::PH_SEEK_MAGIC : phase_ff;
   assign eff_comment = file_start ? 1'b0 : comment_ff;
   assign eff_acc     = file_start ? '0 : acc_ff;
   assign eff_magic   = file_start ? 8'd0 : magic_ff;
   assign eff_width   = file_start ? '0 : width_ff;
   assign eff_height  = file_start ? '0 : height_ff;

   assign is_space = (stream_byte == pnm_hp_pkg::CH_LF) || (stream_byte == pnm_hp_pkg::CH_CR)
                  || (stream_byte == pnm_hp_pkg::CH_TAB) || (stream_byte == pnm_hp_pkg::CH_SPACE)
                  || (stream_byte == pnm_hp_pkg::CH_VT) || (stream_byte == pnm_hp_pkg::CH_FF);
   assign is_digit = (stream_byte >= pnm_hp_pkg::CH_ZERO) && (stream_byte <= pnm_hp_pkg::CH_NINE);

   assign seek_any = (eff_phase == pnm_hp_pkg::PH_SEEK_MAGIC) || (eff_phase == pnm_hp_pkg::PH_SEEK_W)
                  || (eff_phase == pnm_hp_pkg::PH_SEEK_H) || (eff_phase == pnm_hp_pkg::PH_SEEK_MAX);
   assign num_any  = (eff_phase == pnm_hp_pkg::PH_NUM_W) || (eff_phase == pnm_hp_pkg::PH_NUM_H)
                  || (eff_phase == pnm_hp_pkg::PH_NUM_MAX);

   assign field_w   = (eff_phase == pnm_hp_pkg::PH_SEEK_W) || (eff_phase == pnm_hp_pkg::PH_NUM_W);
   assign field_h   = (eff_phase == pnm_hp_pkg::PH_SEEK_H) || (eff_phase == pnm_hp_pkg::PH_NUM_H);
   assign field_max = (eff_phase == pnm_hp_pkg::PH_SEEK_MAX)
                   || (eff_phase == pnm_hp_pkg::PH_NUM_MAX);

   // token ends on a non-digit that is not skipped
   assign tok_end = !is_digit && ((num_any)
                 || (seek_any && !eff_comment && (stream_byte != pnm_hp_pkg::CH_HASH)
                     && !is_space && (eff_phase != pnm_hp_pkg::PH_SEEK_MAGIC)));
   assign tok_val = num_any ? eff_acc : '0;
   assign tok_dim = (tok_val > ACC_BITS'(DIM_MAX)) ? DIM_BITS'(DIM_MAX)
                                                   : tok_val[DIM_BITS-1:0];

   // multiply-by-ten accumulate, saturating
   assign acc_base  = num_any ? eff_acc : '0;
   assign digit_val = 4'(stream_byte - pnm_hp_pkg::CH_ZERO);
   assign acc_prod  = PROD_W'(acc_base) * PROD_W'(pnm_hp_pkg::DEC_RADIX) + PROD_W'(digit_val);
   assign acc_next  = (acc_prod > PROD_W'(ACC_CAP)) ? ACC_BITS'(ACC_CAP)
                                                    : acc_prod[ACC_BITS-1:0];

   assign magic_known = (eff_magic == pnm_hp_pkg::CH_FIVE) || (eff_magic == pnm_hp_pkg::CH_SIX);
   assign too_large   = tok_val >= ACC_BITS'(pnm_hp_pkg::MAXVAL_LIMIT);

   assign width_ext  = 32'(eff_width);
   assign height_ext = 32'(eff_height);

   // next state
   always_comb begin
      phase_in   = eff_phase;
      comment_in = eff_comment;
      acc_in     = eff_acc;
      magic_in   = eff_magic;
      width_in   = eff_width;
      height_in  = eff_height;
      if (seek_any && eff_comment) begin
         if (stream_byte == pnm_hp_pkg::CH_LF) comment_in = 1'b0;
      end else if (seek_any && (stream_byte == pnm_hp_pkg::CH_HASH)) begin
         comment_in = 1'b1;
      end else if (seek_any && is_space) begin
         comment_in = eff_comment;
      end else if (eff_phase == pnm_hp_pkg::PH_SEEK_MAGIC) begin
         phase_in = pnm_hp_pkg::PH_MAGIC2;
      end else if (eff_phase == pnm_hp_pkg::PH_MAGIC2) begin
         magic_in = stream_byte;
         phase_in = pnm_hp_pkg::PH_SEEK_W;
      end else if ((seek_any || num_any) && is_digit) begin
         acc_in = acc_next;
         unique case (eff_phase)
            pnm_hp_pkg::PH_SEEK_W:   phase_in = pnm_hp_pkg::PH_NUM_W;
            pnm_hp_pkg::PH_SEEK_H:   phase_in = pnm_hp_pkg::PH_NUM_H;
            pnm_hp_pkg::PH_SEEK_MAX: phase_in = pnm_hp_pkg::PH_NUM_MAX;
            default:                 phase_in = eff_phase;
         endcase
      end else if (tok_end) begin
         acc_in = '0;
         priority if (field_w) begin
            width_in = tok_dim;
            phase_in = pnm_hp_pkg::PH_SEEK_H;
         end else if (field_h) begin
            height_in = tok_dim;
            phase_in  = pnm_hp_pkg::PH_SEEK_MAX;
         end else if (magic_known && too_large) begin
            phase_in = pnm_hp_pkg::PH_HALT;
         end else begin
            phase_in = pnm_hp_pkg::PH_DATA;
         end
      end
   end

   // result of this beat
   always_comb begin
      result              = '0;
      result.kind         = pnm_hp_pkg::KIND_HEADER;
      result.image_width  = width_ext[15:0];
      result.image_height = height_ext[15:0];
      if (eff_phase == pnm_hp_pkg::PH_DATA) begin
         result.emit       = 1'b1;
         result.kind       = pnm_hp_pkg::KIND_DATA;
         result.pixel_byte = stream_byte;
      end else if (tok_end && field_max) begin
         result.emit = 1'b1;
         if (magic_known && too_large) begin
            result.kind = pnm_hp_pkg::KIND_ERROR;
         end else begin
            result.kind       = pnm_hp_pkg::KIND_HEADER;
            result.max_sample = (tok_val > ACC_BITS'(pnm_hp_pkg::SAMPLE_MAX))
                              ? pnm_hp_pkg::SAMPLE_MAX : tok_val[15:0];
            if (!magic_known) begin
               result.image_kind = pnm_hp_pkg::IK_UNKNOWN;
            end else if (eff_magic == pnm_hp_pkg::CH_FIVE) begin
               result.image_kind = (tok_val >= ACC_BITS'(pnm_hp_pkg::MAXVAL_WIDE))
                                 ? pnm_hp_pkg::IK_GRAY16 : pnm_hp_pkg::IK_GRAY8;
            end else begin
               result.image_kind = (tok_val >= ACC_BITS'(pnm_hp_pkg::MAXVAL_WIDE))
                                 ? pnm_hp_pkg::IK_RGB48 : pnm_hp_pkg::IK_RGB24;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pnm_hp_pkg::PH_SEEK_MAGIC;
         comment_ff <= 1'b0;
         acc_ff     <= '0;
         magic_ff   <= 8'd0;
         width_ff   <= '0;
         height_ff  <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         acc_ff     <= acc_in;
         magic_ff   <= magic_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
      end
   end

   `PNM_ASSERT_NEXT(a_error_halts, step_en && result.emit && (result.kind == pnm_hp_pkg::KIND_ERROR), phase_ff == pnm_hp_pkg::PH_HALT, "error result did not halt the parse")
   `PNM_ASSERT_IMPL(a_halt_silent, step_en && !file_start && (phase_ff == pnm_hp_pkg::PH_HALT), !result.emit, "result emitted while halted")

endmodule

`default_nettype wire

// File: src/pnm_header_parser.sv
// top level of the binary pnm header parser
//
// req channel: one beat per file byte; req_tuser high marks the first byte
// of a new file and restarts the parse from that byte.
// rsp channel: at most one beat per input byte. rsp_tuser gives the kind:
// header complete, pixel data byte, or maxval too large. after an error the
// parser drops bytes until the next start beat.
// path: a byte that yields a result reaches rsp through the input register,
// then the result register.
// throughput: one byte per cycle while rsp is not stalled; the parse state
// is a single register set, one step per byte with one multiply-by-ten accumulate.
// stall: when rsp_tready is low with a result held, the input register
// holds its byte and req_tready drops once it is full; bytes that give no
// result still need the result register free to move on.
// reset: synchronous; the parse restarts looking for the magic, both
// channels empty.
`default_nettype none

`include "pnm_header_parser_macros.svh"

module pnm_header_parser #(
   parameter int DIM_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // stream_byte [7:0]
   input  wire logic        req_tuser,   // file_start [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // image_width [15:0], image_height [31:16],
                                         // max_sample [47:32], image_kind [50:48],
                                         // pixel_byte [58:51], zero [63:59]
   output logic [1:0]       rsp_tuser    // result_kind [1:0]
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_start_ff;
   logic                   advance;
   logic                   req_beat;
   pnm_hp_pkg::result_type step_res;
   logic                   out_valid_ff, out_valid_in;
   pnm_hp_pkg::result_type out_res_ff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = step_res.emit;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   pnm_hp_parse #(
      .DIM_BITS (DIM_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .stream_byte (in_byte_ff),
      .file_start  (in_start_ff),
      .result      (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (advance) out_res_ff <= step_res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tdata  = {5'd0, out_res_ff.pixel_byte, out_res_ff.image_kind,
                        out_res_ff.max_sample, out_res_ff.image_height,
                        out_res_ff.image_width};

   `PNM_ASSERT_IMPL(a_full_take_moves, req_beat && in_valid_ff, advance, "beat taken over a held byte")
   `PNM_ASSERT_IMPL(a_result_from_step, $rose(out_valid_ff), $past(advance), "result appeared without a step")
   `PNM_ASSERT_IMPL(a_data_clean, rsp_tvalid && (rsp_tuser == pnm_hp_pkg::KIND_DATA), (out_res_ff.max_sample == 16'd0) && (out_res_ff.image_kind == pnm_hp_pkg::IK_UNKNOWN), "data beat carries header fields")

endmodule

`default_nettype wire
